// ===== sv/ube_pkg.sv =====
// Shared types, character constants and lookup functions for the URL byte escaper.
`timescale 1ns / 1ps

package ube_pkg;

    // One input item: a raw text byte and its end-of-text mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } t_in_item;

    // One result item: an escaped byte with its run and text marks
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       text_end;
    } t_out_item;

    // How a byte expands
    typedef enum logic [1:0] {
        KIND_SAFE,
        KIND_AMP,
        KIND_HEX
    } t_kind;

    // Classified item as it waits in the queue
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       final_mark;
    } t_entry;

    localparam int unsigned RUN_IDX_W = 3;

    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_PCT = 8'h25;

    localparam logic [7:0] AMP_SEQ [5] = '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B};

    localparam logic [RUN_IDX_W-1:0] LAST_SAFE = 3'd0;
    localparam logic [RUN_IDX_W-1:0] LAST_HEX  = 3'd2;
    localparam logic [RUN_IDX_W-1:0] LAST_AMP  = 3'd4;

    // Uppercase hex digit for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

    // Index of the last byte of a run of the given kind
    function automatic logic [RUN_IDX_W-1:0] run_last(input t_kind kind);
        logic [RUN_IDX_W-1:0] last;
        unique case (kind)
            KIND_SAFE: last = LAST_SAFE;
            KIND_AMP:  last = LAST_AMP;
            KIND_HEX:  last = LAST_HEX;
            default:   last = LAST_SAFE;
        endcase
        return last;
    endfunction

endpackage

// ===== sv/ube_front.sv =====
// Front end: accepts input items and classifies each byte by how it expands.
`timescale 1ns / 1ps

module ube_front (
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ube_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_busy,
    output logic              o_push,
    output ube_pkg::t_entry   o_entry
);

    logic safe;

    // Letters, digits and the safe punctuation pass through
    always_comb begin
        case (i_item.in_byte) inside
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
            "-", "_", ".", "+", "!", "*", "'", "(", ")", ",",
            "%", "#", "@", "?", "=", ";", ":", "/", "$":
                safe = 1'b1;
            default:
                safe = 1'b0;
        endcase
    end

    // Classify into the queue entry
    always_comb begin
        o_entry.data       = i_item.in_byte;
        o_entry.final_mark = i_item.in_final;
        if (safe) begin
            o_entry.kind = ube_pkg::KIND_SAFE;
        end else if (i_item.in_byte == ube_pkg::CH_AMP) begin
            o_entry.kind = ube_pkg::KIND_AMP;
        end else begin
            o_entry.kind = ube_pkg::KIND_HEX;
        end
    end

    // Hold off the sender while the queue is full or in reset
    assign o_busy = i_full | ~i_rst_n;
    assign o_push = i_start & ~o_busy;

endmodule

// ===== sv/ube_queue.sv =====
// Small FIFO of classified items between front end and emitter.
`timescale 1ns / 1ps

module ube_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ube_pkg::t_entry i_entry,
    input  logic            i_pop,
    output ube_pkg::t_entry o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ube_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_head  = r_mem[r_rd];

    // Pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== sv/ube_back.sv =====
// Emitter: walks the run of the item at the queue head, one byte per cycle.
`timescale 1ns / 1ps

module ube_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ube_pkg::t_entry    i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_strobe,
    output ube_pkg::t_out_item o_result
);

    logic [ube_pkg::RUN_IDX_W-1:0] r_idx, n_idx;
    logic                          last;
    logic [7:0]                    cur_byte;
    logic                          r_strobe;
    ube_pkg::t_out_item            r_out;

    assign last  = (r_idx == ube_pkg::run_last(i_head.kind));
    assign o_pop = ~i_empty & last;

    // Byte at the current position of the run
    always_comb begin
        unique case (i_head.kind)
            ube_pkg::KIND_SAFE: cur_byte = i_head.data;
            ube_pkg::KIND_AMP: begin
                cur_byte = (r_idx <= ube_pkg::LAST_AMP) ? ube_pkg::AMP_SEQ[r_idx] : 8'h00;
            end
            ube_pkg::KIND_HEX: begin
                if (r_idx == 3'd0) begin
                    cur_byte = ube_pkg::CH_PCT;
                end else if (r_idx == 3'd1) begin
                    cur_byte = ube_pkg::hex_digit(i_head.data[7:4]);
                end else begin
                    cur_byte = ube_pkg::hex_digit(i_head.data[3:0]);
                end
            end
            default: cur_byte = i_head.data;
        endcase
    end

    // Run position
    always_comb begin
        n_idx = r_idx;
        if (!i_empty) begin
            n_idx = last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_strobe <= ~i_empty;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        r_out.out_byte <= cur_byte;
        r_out.run_end  <= last;
        r_out.text_end <= last & i_head.final_mark;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ===== sv/url_byte_escaper.sv =====
// Top level of the URL byte escaper: front end, item queue and emitter.
//
//  channel   ports                         handshake
//  input     i_item (in_byte, in_final)    i_start high and o_busy low at the clock edge
//  result    o_result (out_byte, run_end,  o_strobe high for one cycle, always taken
//            text_end)
//
// A pass-through byte expands to 1 output byte, a hex escape to 3 and an ampersand to 5; the
// emitter produces one output byte per cycle, so it sets the rate.
// With the queue empty, an accepted item is written into the queue and its first output byte
// is then registered in the emitter's output register before it is on the ports.
// Synchronous active-low reset empties the queue; o_busy is high during reset.
// Out of reset, o_busy rises only when the queue is full, i.e. while expansions back up the input.
`timescale 1ns / 1ps

module url_byte_escaper #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ube_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_strobe,
    output ube_pkg::t_out_item o_result
);

    ube_pkg::t_entry entry, head;
    logic            push, pop, q_empty, q_full;

    // Accept and classify
    ube_front u_front (
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_busy  (o_busy),
        .o_push  (push),
        .o_entry (entry)
    );

    // Decoupling queue
    ube_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Emit runs
    ube_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // An item taken into an empty queue shows its first byte once it has passed the queue and output register
    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_empty) |=> ##1 o_strobe)
        else $error("first byte of item missing");

    // A run is never broken: a byte without run_end is followed by another
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.run_end) |=> o_strobe)
        else $error("run interrupted");

    // End of text only on the last byte of a run
    a_text_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.text_end) |-> o_result.run_end)
        else $error("text_end outside run end");

endmodule

// ===== tb/sv/tb_url_byte_escaper.sv =====
// Self-checking testbench for the URL byte escaper: directed table, random texts, scoreboard.
`timescale 1ns / 1ps

module tb_url_byte_escaper;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int ITEMS_PER_PH = 50;
    localparam int DRAIN_CYCLES = 8;

    localparam string HEX_DIGITS = "0123456789ABCDEF";
    localparam string SAFE_PUNCT = "-_.+!*'(),%#@?=;:/$";
    localparam logic [39:0] AMP_ENTITY = "&amp;";

    // One directed row: byte, end mark, and a typed run (len 0 = use the predictor)
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic [2:0]  run_len;
        logic [39:0] run;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    ube_pkg::t_in_item   i_item;
    logic                o_busy;
    logic                o_strobe;
    ube_pkg::t_out_item  o_result;

    // Typed run that travels alongside the item being offered
    logic [2:0]  drv_run_len;
    logic [39:0] drv_run;

    ube_pkg::t_out_item pending_out [$];
    int                 mismatch_cnt = 0;
    int                 cycle_cnt = 0;

    // Runs are stored first byte in the most significant position
    t_dir_row dir_rows [24] = '{
        '{"A",   1'b0, 3'd1, "A"},
        '{"z",   1'b0, 3'd1, "z"},
        '{"0",   1'b0, 3'd0, 40'h0},
        '{"9",   1'b1, 3'd0, 40'h0},
        '{"Z",   1'b0, 3'd0, 40'h0},
        '{"a",   1'b0, 3'd0, 40'h0},
        '{8'h00, 1'b0, 3'd3, "%00"},
        '{8'hFF, 1'b1, 3'd3, "%FF"},
        '{8'h80, 1'b0, 3'd3, "%80"},
        '{8'h01, 1'b0, 3'd3, "%01"},
        '{"&",   1'b0, 3'd5, "&amp;"},
        '{"&",   1'b1, 3'd5, "&amp;"},
        '{"'",   1'b0, 3'd1, "'"},
        '{" ",   1'b0, 3'd3, "%20"},
        '{"-",   1'b0, 3'd0, 40'h0},
        '{"$",   1'b0, 3'd0, 40'h0},
        '{"/",   1'b1, 3'd0, 40'h0},
        '{"%",   1'b0, 3'd0, 40'h0},
        '{8'h7E, 1'b0, 3'd0, 40'h0},
        '{8'h7F, 1'b0, 3'd0, 40'h0},
        '{8'h5B, 1'b0, 3'd0, 40'h0},
        '{8'h60, 1'b0, 3'd0, 40'h0},
        '{8'h0A, 1'b0, 3'd0, 40'h0},
        '{8'h7B, 1'b1, 3'd0, 40'h0}
    };

    url_byte_escaper dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Letters, digits and the safe punctuation pass through
    function automatic logic url_safe(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
            return 1'b1;
        end
        case (c)
            "-", "_", ".", "+", "!", "*", "'", "(", ")", ",",
            "%", "#", "@", "?", "=", ";", ":", "/", "$": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Escaped run for one byte; returns its length, run packed first byte high
    function automatic logic [2:0] escape_run(input logic [7:0] c, output logic [39:0] run);
        run = '0;
        if (url_safe(c)) begin
            run[7:0] = c;
            return 3'd1;
        end else if (c == ube_pkg::CH_AMP) begin
            run = AMP_ENTITY;
            return 3'd5;
        end
        run[23:0] = {ube_pkg::CH_PCT, HEX_DIGITS[c[7:4]], HEX_DIGITS[c[3:0]]};
        return 3'd3;
    endfunction

    // Random byte biased toward each kind of run
    function automatic logic [7:0] pick_byte();
        int r;
        int idx;
        r = $urandom_range(99);
        if (r < 35) begin
            idx = $urandom_range(61);
            if (idx < 10) return 8'("0" + idx);
            if (idx < 36) return 8'("A" + idx - 10);
            return 8'("a" + idx - 36);
        end else if (r < 50) begin
            return SAFE_PUNCT[$urandom_range(SAFE_PUNCT.len() - 1)];
        end else if (r < 62) begin
            return ube_pkg::CH_AMP;
        end
        return 8'($urandom_range(255));
    endfunction

    // Offer one item, optionally after an idle gap, and wait until it is taken
    task automatic send_byte(input ube_pkg::t_in_item it, input logic [2:0] run_len,
                             input logic [39:0] run, input int idle_pct);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(4, 1);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_item      <= it;
        drv_run_len <= run_len;
        drv_run     <= run;
        do @(posedge i_clk); while (!(i_rst_n && !o_busy));
    endtask

    // One random text; now and then the end mark is misplaced or missing
    task automatic send_text(input int idle_pct, inout int sent);
        int                len;
        ube_pkg::t_in_item it;
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
            it.in_byte  = pick_byte();
            it.in_final = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
            send_byte(it, 3'd0, 40'h0, idle_pct);
            sent++;
        end
    endtask

    // Hold off input until every expected byte has come out
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_out.size() != 0) @(posedge i_clk);
    endtask

    // Scoreboard: check results, then record the run of each accepted item
    always @(posedge i_clk) begin : scoreboard
        ube_pkg::t_out_item want;
        logic [2:0]         n;
        logic [39:0]        run;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_out.size() == 0) begin
                    $error("result with none expected: out_byte %h", o_result.out_byte);
                    mismatch_cnt++;
                end else begin
                    want = pending_out.pop_front();
                    if (o_result.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, o_result.out_byte);
                        mismatch_cnt++;
                    end
                    if (o_result.run_end !== want.run_end) begin
                        $error("run_end: expected %b, got %b", want.run_end, o_result.run_end);
                        mismatch_cnt++;
                    end
                    if (o_result.text_end !== want.text_end) begin
                        $error("text_end: expected %b, got %b", want.text_end, o_result.text_end);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                if (drv_run_len != 3'd0) begin
                    n   = drv_run_len;
                    run = drv_run;
                end else begin
                    n = escape_run(i_item.in_byte, run);
                end
                for (int k = 0; k < n; k++) begin
                    want.out_byte = run[8 * (n - 1 - k) +: 8];
                    want.run_end  = (k == n - 1);
                    want.text_end = (k == n - 1) && i_item.in_final;
                    pending_out.push_back(want);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("url_byte_escaper regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial begin : stim
        int                idle_pct [3];
        int                sent;
        ube_pkg::t_in_item it;
        idle_pct     = '{0, 64, 33};
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_item       = '0;
        drv_run_len  = '0;
        drv_run      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, back to back
        foreach (dir_rows[i]) begin
            it.in_byte  = dir_rows[i].ch;
            it.in_final = dir_rows[i].fin;
            send_byte(it, dir_rows[i].run_len, dir_rows[i].run, 0);
        end
        drain();

        // Random texts, one phase per idle setting
        foreach (idle_pct[p]) begin
            sent = 0;
            while (sent < ITEMS_PER_PH) send_text(idle_pct[p], sent);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_out.size() != 0) begin
            $error("out_byte: expected %0d more results, got none", pending_out.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("url_byte_escaper regression: pass");
        end else begin
            $display("url_byte_escaper regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ube_pkg.sv
sv/ube_front.sv
sv/ube_queue.sv
sv/ube_back.sv
sv/url_byte_escaper.sv
tb/sv/tb_url_byte_escaper.sv
